// File: hdl/lfcs_pkg.sv
`default_nettype none
package lfcs_pkg;

  // line buffer geometry
  localparam int LINE_BYTES  = 64;
  localparam int RANGE_SLOTS = 5;
  localparam int RANGE_REGS  = 5;
  localparam int ADDR_W      = $clog2(LINE_BYTES);
  localparam int FIELD_W     = $clog2(LINE_BYTES + 1);
  localparam int POS_W       = 10;

  // configuration port geometry
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam logic [7:0] NEWLINE_BYTE = 8'd10;
  localparam logic [7:0] TAB_BYTE     = 8'd9;

  // register indexes
  typedef enum logic [2:0] {
    REG_CUT_MODE  = 3'd0,
    REG_DELIMITER = 3'd1,
    REG_SUPPRESS  = 3'd2,
    REG_RANGE_0   = 3'd3,
    REG_RANGE_1   = 3'd4,
    REG_RANGE_2   = 3'd5,
    REG_RANGE_3   = 3'd6,
    REG_RANGE_4   = 3'd7
  } reg_idx_t;

  // one selection range: open flag, inclusive end, 1-based start
  typedef struct packed {
    logic             open_end;
    logic [POS_W-1:0] hi;
    logic [POS_W-1:0] lo;
  } range_t;

  typedef struct packed {
    logic                       cut_mode;
    logic [7:0]                 delimiter;
    logic                       suppress;
    range_t [RANGE_REGS-1:0]    ranges;
  } lfcs_cfg_t;

  // controller to datapath
  typedef struct packed {
    logic store;      // buffer the input byte
    logic init;       // rewind to the first byte, restart field tracking
    logic clr_dseen;  // clear the delimiter scan result
    logic scan;       // fold the current byte into the delimiter scan
    logic adv;        // move to the next buffered byte
    logic load_byte;  // put the current byte into the output register
    logic load_nl;    // put the closing newline into the output register
    logic clear;      // drop the line
  } lfcs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pending;
    logic in_nl;
    logic idx_done;
    logic emit;
    logic dseen;
    logic out_free;
    logic cut_mode;
    logic suppress;
  } lfcs_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_NEWLINE
  } lfcs_state_t;

  // true when a 1-based position falls in any active range
  function automatic logic sel_hit(input logic [POS_W-1:0] pos,
                                   input range_t [RANGE_REGS-1:0] ranges);
    logic hit;
    hit = 1'b0;
    for (int s = 0; s < RANGE_SLOTS; s++) begin
      if ((ranges[s].lo != '0) && (pos >= ranges[s].lo) &&
          (ranges[s].open_end || (pos <= ranges[s].hi))) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage
`default_nettype wire

// File: hdl/lfcs_in_if.sv
`default_nettype none
interface lfcs_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;

  modport source (output valid, output action, output data_byte, input ready);
  modport sink (input valid, input action, input data_byte, output ready);
endinterface
`default_nettype wire

// File: hdl/lfcs_out_if.sv
`default_nettype none
interface lfcs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink (input valid, input out_byte, input last, output ready);
endinterface
`default_nettype wire

// File: hdl/line_field_column_selector.sv
// line field and column selector
//
// in_ch carries one beat per text byte (action 0) or an end-of-input flush
// (action 1). out_ch returns the selected bytes of each finished line, with
// last set on the closing newline. Registers sit on the cfg_ APB port; the
// user must write them only while no line is being replayed (not enforced).
//
// a data byte is stored in the line buffer. a newline, or a flush with a
// pending line, starts replay from the line buffer: in field mode a
// delimiter scan, then, unless suppress drops a line with no delimiter,
// the replay of the line and the load of the newline; in character mode
// only the replay and the newline. the kept length is at most 63 bytes.
// each output beat waits for out_ch.ready; while a line replays in_ch.ready
// stays low, and a new byte is taken as soon as the closing newline sits in
// the output register.
//
// synchronous reset clears the registers to field mode, tab delimiter, no
// suppress, no ranges, and empties the line. a stalled receiver holds the
// current beat, replay waits at its next selected byte; nothing is dropped.
`default_nettype none
module line_field_column_selector (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  lfcs_in_if.sink                              in_ch,
  lfcs_out_if.source                           out_ch,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [lfcs_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [lfcs_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [lfcs_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                                 cfg_pready
);
  import lfcs_pkg::*;

  lfcs_cfg_t  cfg;
  lfcs_cmd_t  cmd;
  lfcs_stat_t stat;
  logic       in_ready;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_last;

  // configuration registers
  lfcs_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // sequencer
  lfcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .stat      (stat),
    .in_ready  (in_ready),
    .cmd       (cmd)
  );

  // line buffer and output register
  lfcs_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd       (cmd),
    .in_data   (in_ch.data_byte),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .stat      (stat)
  );

  assign in_ch.ready     = in_ready;
  assign out_ch.valid    = out_valid;
  assign out_ch.out_byte = out_byte;
  assign out_ch.last     = out_last;

endmodule
`default_nettype wire

// File: hdl/lfcs_regs.sv
`default_nettype none
module lfcs_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_psel,
  input  wire logic                           cfg_penable,
  input  wire logic                           cfg_pwrite,
  input  wire logic [lfcs_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [lfcs_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [lfcs_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                                cfg_pready,
  output lfcs_pkg::lfcs_cfg_t                 cfg
);
  import lfcs_pkg::*;

  lfcs_cfg_t cfg_r;
  lfcs_cfg_t cfg_nxt;
  reg_idx_t  idx;
  logic      wr_en;

  assign idx        = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_CUT_MODE:  cfg_nxt.cut_mode  = cfg_pwdata[0];
        REG_DELIMITER: cfg_nxt.delimiter = cfg_pwdata[7:0];
        REG_SUPPRESS:  cfg_nxt.suppress  = cfg_pwdata[0];
        REG_RANGE_0:   cfg_nxt.ranges[0] = range_t'(cfg_pwdata[$bits(range_t)-1:0]);
        REG_RANGE_1:   cfg_nxt.ranges[1] = range_t'(cfg_pwdata[$bits(range_t)-1:0]);
        REG_RANGE_2:   cfg_nxt.ranges[2] = range_t'(cfg_pwdata[$bits(range_t)-1:0]);
        REG_RANGE_3:   cfg_nxt.ranges[3] = range_t'(cfg_pwdata[$bits(range_t)-1:0]);
        REG_RANGE_4:   cfg_nxt.ranges[4] = range_t'(cfg_pwdata[$bits(range_t)-1:0]);
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{cut_mode: 1'b0, delimiter: TAB_BYTE, suppress: 1'b0, ranges: '0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // register read mux
  always_comb begin
    case (idx)
      REG_CUT_MODE:  cfg_prdata = CFG_DATA_W'(cfg_r.cut_mode);
      REG_DELIMITER: cfg_prdata = CFG_DATA_W'(cfg_r.delimiter);
      REG_SUPPRESS:  cfg_prdata = CFG_DATA_W'(cfg_r.suppress);
      REG_RANGE_0:   cfg_prdata = CFG_DATA_W'(cfg_r.ranges[0]);
      REG_RANGE_1:   cfg_prdata = CFG_DATA_W'(cfg_r.ranges[1]);
      REG_RANGE_2:   cfg_prdata = CFG_DATA_W'(cfg_r.ranges[2]);
      REG_RANGE_3:   cfg_prdata = CFG_DATA_W'(cfg_r.ranges[3]);
      REG_RANGE_4:   cfg_prdata = CFG_DATA_W'(cfg_r.ranges[4]);
      default:       cfg_prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: hdl/lfcs_dpath.sv
`default_nettype none
module lfcs_dpath (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire lfcs_pkg::lfcs_cfg_t cfg,
  input  wire lfcs_pkg::lfcs_cmd_t cmd,
  input  wire logic [7:0]          in_data,
  input  wire logic                out_ready,
  output logic                     out_valid,
  output logic [7:0]               out_byte,
  output logic                     out_last,
  output lfcs_pkg::lfcs_stat_t     stat
);
  import lfcs_pkg::*;

  logic [7:0]         line_mem_r [LINE_BYTES];
  logic [7:0]         rdata_r;
  logic [ADDR_W-1:0]  len_r, len_nxt;
  logic               trunc_r, trunc_nxt;
  logic               dseen_r, dseen_nxt;
  logic [ADDR_W-1:0]  idx_r, idx_nxt;
  logic [FIELD_W-1:0] field_r, field_nxt;
  logic               field_sel_r, field_sel_nxt;
  logic               have_em_r, have_em_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_byte_r;
  logic               out_last_r;
  logic               wr_en;
  logic               is_delim;
  logic               sel_first;
  logic               sel_next;
  logic               sel_char;
  logic [FIELD_W-1:0] field_inc;

  assign is_delim  = (rdata_r == cfg.delimiter);
  assign field_inc = field_r + FIELD_W'(1);
  assign sel_first = sel_hit(POS_W'(1), cfg.ranges);
  assign sel_next  = sel_hit(POS_W'(field_inc), cfg.ranges);
  assign sel_char  = sel_hit(POS_W'(idx_r) + POS_W'(1), cfg.ranges);
  assign wr_en     = cmd.store && !trunc_r && (len_r < ADDR_W'(LINE_BYTES - 1));

  // line buffer, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem_r[len_r] <= in_data;
    end
    rdata_r <= line_mem_r[idx_nxt];
  end

  // line length, truncation and delimiter scan
  always_comb begin
    len_nxt   = len_r;
    trunc_nxt = trunc_r;
    dseen_nxt = dseen_r;
    if (wr_en) begin
      len_nxt = len_r + ADDR_W'(1);
    end else if (cmd.store && !trunc_r) begin
      trunc_nxt = 1'b1;
    end
    if (cmd.clr_dseen) begin
      dseen_nxt = 1'b0;
    end else if (cmd.scan && is_delim) begin
      dseen_nxt = 1'b1;
    end
    if (cmd.clear) begin
      len_nxt   = '0;
      trunc_nxt = 1'b0;
      dseen_nxt = 1'b0;
    end
  end

  // read index and field tracking
  always_comb begin
    idx_nxt       = idx_r;
    field_nxt     = field_r;
    field_sel_nxt = field_sel_r;
    have_em_nxt   = have_em_r;
    if (cmd.init) begin
      idx_nxt       = '0;
      field_nxt     = FIELD_W'(1);
      field_sel_nxt = sel_first;
      have_em_nxt   = sel_first;
    end else if (cmd.adv) begin
      idx_nxt = idx_r + ADDR_W'(1);
      if (is_delim) begin
        field_nxt     = field_inc;
        field_sel_nxt = sel_next;
        have_em_nxt   = have_em_r || sel_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      trunc_r     <= 1'b0;
      dseen_r     <= 1'b0;
      idx_r       <= '0;
      field_r     <= FIELD_W'(1);
      field_sel_r <= 1'b0;
      have_em_r   <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      trunc_r     <= trunc_nxt;
      dseen_r     <= dseen_nxt;
      idx_r       <= idx_nxt;
      field_r     <= field_nxt;
      field_sel_r <= field_sel_nxt;
      have_em_r   <= have_em_nxt;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_byte || cmd.load_nl) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      out_byte_r <= rdata_r;
      out_last_r <= 1'b0;
    end else if (cmd.load_nl) begin
      out_byte_r <= NEWLINE_BYTE;
      out_last_r <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

  // status toward the controller
  always_comb begin
    stat.pending  = (len_r != '0) || trunc_r;
    stat.in_nl    = (in_data == NEWLINE_BYTE);
    stat.idx_done = (idx_r == len_r);
    stat.dseen    = dseen_r;
    stat.out_free = !out_valid_r || out_ready;
    stat.cut_mode = cfg.cut_mode;
    stat.suppress = cfg.suppress;
    if (cfg.cut_mode) begin
      stat.emit = sel_char;
    end else if (!dseen_r) begin
      stat.emit = 1'b1;
    end else if (is_delim) begin
      stat.emit = sel_next && have_em_r;
    end else begin
      stat.emit = field_sel_r;
    end
  end

endmodule
`default_nettype wire

// File: hdl/lfcs_ctrl.sv
`default_nettype none
module lfcs_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_action,
  input  wire lfcs_pkg::lfcs_stat_t stat,
  output logic                      in_ready,
  output lfcs_pkg::lfcs_cmd_t       cmd
);
  import lfcs_pkg::*;

  lfcs_state_t state_r, state_nxt;
  logic        line_end;

  // a newline always ends the line, a flush only when something is pending
  assign line_end = in_valid && ((!in_action && stat.in_nl) || (in_action && stat.pending));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (line_end) begin
          state_nxt = stat.cut_mode ? ST_EMIT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.idx_done) begin
          state_nxt = (!stat.dseen && stat.suppress) ? ST_IDLE : ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.idx_done) begin
          state_nxt = ST_NEWLINE;
        end
      end
      ST_NEWLINE: begin
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // commands
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && !in_action && !stat.in_nl) begin
          cmd.store = 1'b1;
        end else if (line_end) begin
          cmd.init      = 1'b1;
          cmd.clr_dseen = 1'b1;
        end
      end
      ST_SCAN: begin
        if (stat.idx_done) begin
          if (!stat.dseen && stat.suppress) begin
            cmd.clear = 1'b1;
          end else begin
            cmd.init = 1'b1;
          end
        end else begin
          cmd.scan = 1'b1;
          cmd.adv  = 1'b1;
        end
      end
      ST_EMIT: begin
        if (!stat.idx_done) begin
          if (!stat.emit) begin
            cmd.adv = 1'b1;
          end else if (stat.out_free) begin
            cmd.load_byte = 1'b1;
            cmd.adv       = 1'b1;
          end
        end
      end
      ST_NEWLINE: begin
        if (stat.out_free) begin
          cmd.load_nl = 1'b1;
          cmd.clear   = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: hdl/lfcs_checker.sv
`default_nettype none
module lfcs_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       in_action,
  input wire logic [7:0] in_data,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       out_last
);
  import lfcs_pkg::*;

  // reset empties the output register
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output beat valid after reset");

  // input is held off while a line is still replaying
  a_replay_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> !in_ready)
    else $error("input accepted during line replay");

  // a plain data byte never starts output
  a_byte_no_output: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_action && (in_data != NEWLINE_BYTE) &&
     (!out_valid || out_ready)) |=> !out_valid)
    else $error("output produced by a data byte");

  // a stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_byte) && $stable(out_last)))
    else $error("stalled output beat changed");

endmodule

bind line_field_column_selector lfcs_checker u_lfcs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_action (in_ch.action),
  .in_data   (in_ch.data_byte),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .out_last  (out_ch.last)
);
`default_nettype wire

// File: test/line_field_column_selector_test.sv
`timescale 1ns / 1ps
module line_field_column_selector_test;
  import lfcs_pkg::*;

  localparam int RANDOM_BEATS  = 430;
  localparam int SETTLE_CYCLES = 2 * LINE_BYTES + 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int PRINT_LIMIT   = 50;

  // one input beat and one output beat
  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } text_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } cut_byte_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  lfcs_in_if  in_ch ();
  lfcs_out_if out_ch ();

  line_field_column_selector uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // text beats waiting to be driven, selected bytes waiting to come out
  text_beat_t text_beats_q [$];
  cut_byte_t  cut_output_q [$];

  int unsigned beats_queued = 0;
  int unsigned beats_accepted = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int          random_beats = 0;
  int          tx_gap_left = 0;
  int          rx_stall_left = 0;
  bit          tx_idle_on = 1'b0;
  bit          rx_idle_on = 1'b0;
  int          hold_asked = 0;
  int          hold_served = 0;
  int          hold_left = 0;

  // shadow of the register file
  logic       cfg_char_mode = 1'b0;
  logic [7:0] cfg_delim = TAB_BYTE;
  logic       cfg_suppress = 1'b0;
  range_t     cfg_ranges [RANGE_REGS];

  // shadow of the line buffer
  logic [7:0] line_buf [LINE_BYTES];
  int         kept_len = 0;
  bit         line_cut = 1'b0;

  initial begin
    for (int s = 0; s < RANGE_REGS; s++) cfg_ranges[s] = '0;
  end

  task automatic report_mismatch(string what);
    if (mismatches < PRINT_LIMIT) $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  // does a 1-based position or field number fall in any active range
  function automatic bit position_hit(int unsigned pos);
    for (int s = 0; s < RANGE_SLOTS; s++) begin
      if (cfg_ranges[s].lo == '0 || pos < cfg_ranges[s].lo) continue;
      if (cfg_ranges[s].open_end || pos <= cfg_ranges[s].hi) return 1'b1;
    end
    return 1'b0;
  endfunction

  // replay the buffered line through the selection rules
  task automatic emit_cut_line();
    logic [7:0] run [$];
    cut_byte_t  entry;
    int         field_no;
    int         field_start;
    bit         delim_found;
    bit         first_field;
    int         n;
    if (cfg_char_mode) begin
      for (int i = 0; i < kept_len; i++)
        if (position_hit(i + 1)) run.push_back(line_buf[i]);
    end else begin
      delim_found = 1'b0;
      for (int i = 0; i < kept_len; i++)
        if (line_buf[i] == cfg_delim) delim_found = 1'b1;
      if (!delim_found) begin
        // no delimiter: whole line, unless suppressed
        if (cfg_suppress) return;
        for (int i = 0; i < kept_len; i++) run.push_back(line_buf[i]);
      end else begin
        field_no = 1;
        field_start = 0;
        first_field = 1'b1;
        for (int i = 0; i <= kept_len; i++) begin
          if (i == kept_len || line_buf[i] == cfg_delim) begin
            if (position_hit(field_no)) begin
              if (!first_field) run.push_back(cfg_delim);
              for (int j = field_start; j < i; j++) run.push_back(line_buf[j]);
              first_field = 1'b0;
            end
            field_no++;
            field_start = i + 1;
          end
        end
      end
    end
    run.push_back(NEWLINE_BYTE);
    n = (run.size() > LINE_BYTES) ? LINE_BYTES : run.size();
    for (int k = 0; k < n; k++) begin
      entry.out_byte = run[k];
      entry.last = (k == n - 1);
      cut_output_q.push_back(entry);
    end
  endtask

  // advance the shadow state by one accepted beat
  task automatic cut_predict_beat(logic action, logic [7:0] data_byte);
    if (action) begin
      if (kept_len == 0 && !line_cut) return;
      emit_cut_line();
      kept_len = 0;
      line_cut = 1'b0;
    end else if (data_byte == NEWLINE_BYTE) begin
      emit_cut_line();
      kept_len = 0;
      line_cut = 1'b0;
    end else if (!line_cut) begin
      if (kept_len + 1 < LINE_BYTES) begin
        line_buf[kept_len] = data_byte;
        kept_len++;
      end else begin
        line_cut = 1'b1;
      end
    end
  endtask

  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // input driver
  always @(posedge clk) begin : text_driver
    bit         taken;
    text_beat_t next_beat;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.action <= 1'b0;
      in_ch.data_byte <= '0;
    end else begin
      taken = in_ch.valid && in_ch.ready;
      if (taken) begin
        cut_predict_beat(in_ch.action, in_ch.data_byte);
        beats_accepted++;
        tx_gap_left = (tx_idle_on && $urandom_range(0, 2) == 0) ? idle_length() : 0;
      end
      if (!in_ch.valid || taken) begin
        if (tx_gap_left != 0) begin
          tx_gap_left--;
          in_ch.valid <= 1'b0;
        end else if (text_beats_q.size() != 0) begin
          next_beat = text_beats_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.action <= next_beat.action;
          in_ch.data_byte <= next_beat.data_byte;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted on its own
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_served) begin
      hold_left <= HOLD_CYCLES;
      hold_served <= hold_served + 1;
    end
  end

  // output monitor and receiver stalls
  always @(posedge clk) begin : cut_monitor
    cut_byte_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (cut_output_q.size() == 0) begin
          report_mismatch($sformatf("unexpected beat byte %02h last %0b",
                                    out_ch.out_byte, out_ch.last));
        end else begin
          want = cut_output_q.pop_front();
          if (out_ch.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %02h, expected %02h",
                                      out_ch.out_byte, want.out_byte));
          if (out_ch.last !== want.last)
            report_mismatch($sformatf("last %0b, expected %0b on byte %02h",
                                      out_ch.last, want.last, want.out_byte));
        end
      end
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
      end else if (rx_stall_left != 0) begin
        rx_stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (rx_idle_on && $urandom_range(0, 3) == 0) rx_stall_left = idle_length();
      end
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // APB write, shadowed once the access beat completes
  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_CUT_MODE:  cfg_char_mode = value[0];
      REG_DELIMITER: cfg_delim = value[7:0];
      REG_SUPPRESS:  cfg_suppress = value[0];
      default:       cfg_ranges[idx - REG_RANGE_0] = value[20:0];
    endcase
  endtask

  task automatic queue_beat(logic action, logic [7:0] data_byte);
    text_beat_t b;
    b.action = action;
    b.data_byte = data_byte;
    text_beats_q.push_back(b);
    beats_queued++;
  endtask

  task automatic queue_text(string s);
    for (int i = 0; i < s.len(); i++) queue_beat(1'b0, s[i]);
  endtask

  task automatic wait_results();
    while (beats_accepted != beats_queued || cut_output_q.size() != 0) @(posedge clk);
  endtask

  // block idle: everything out, and any silent replay finished
  task automatic wait_idle();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] span(logic open_end, int hi, int lo);
    return {11'd0, open_end, 10'(hi), 10'(lo)};
  endfunction

  function automatic logic [31:0] random_span();
    logic [31:0] junk;
    logic [9:0]  lo;
    logic [9:0]  hi;
    logic        open_end;
    junk = $urandom();
    case ($urandom_range(0, 9))
      0: begin
        lo = '0;
        hi = 10'($urandom_range(0, 1023));
        open_end = 1'($urandom_range(0, 1));
      end
      1: return {junk[31:21], 21'h1FFFFF};
      2: begin
        // reversed
        lo = 10'($urandom_range(4, 12));
        hi = 10'($urandom_range(1, lo - 1));
        open_end = 1'b0;
      end
      3: begin
        lo = 10'($urandom_range(1, 8));
        hi = 10'($urandom_range(0, 1023));
        open_end = 1'b1;
      end
      4: return junk;
      default: begin
        lo = 10'($urandom_range(1, 10));
        hi = lo + 10'($urandom_range(0, 8));
        open_end = 1'b0;
      end
    endcase
    return {junk[31:21], open_end, hi, lo};
  endfunction

  task automatic random_settings(int phase);
    logic [31:0] junk;
    logic [7:0]  d;
    int          pick;
    junk = $urandom();
    write_reg(REG_CUT_MODE, {junk[31:1], (phase < 2) ? 1'b0 : junk[0]});
    pick = (phase < 2) ? 2 + phase : $urandom_range(0, 5);
    case (pick)
      0:       d = TAB_BYTE;
      1:       d = ",";
      2:       d = 8'h00;
      3:       d = 8'hFF;
      4:       d = " ";
      default: d = 8'($urandom_range(0, 255));
    endcase
    junk = $urandom();
    write_reg(REG_DELIMITER, {junk[31:8], d});
    write_reg(REG_SUPPRESS, $urandom());
    write_reg(REG_RANGE_0, random_span());
    write_reg(REG_RANGE_1, random_span());
    write_reg(REG_RANGE_2, random_span());
    write_reg(REG_RANGE_3, random_span());
    write_reg(REG_RANGE_4, random_span());
  endtask

  // one line of mostly printable text, delimiters mixed in
  task automatic queue_line();
    int         len;
    logic [7:0] b;
    len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 14) : $urandom_range(55, 80);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 2) == 0) b = cfg_delim;
      else if ($urandom_range(0, 9) == 0) b = 8'($urandom_range(0, 255));
      else b = 8'($urandom_range(32, 126));
      queue_beat(1'b0, b);
    end
    if ($urandom_range(0, 99) < 88) queue_beat(1'b0, NEWLINE_BYTE);
    else queue_beat(1'b1, 8'($urandom_range(0, 255)));
    random_beats += len + 1;
    // stray flush with nothing pending
    if ($urandom_range(0, 19) == 0) queue_beat(1'b1, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int phase;
    int phase_goal;
    int phase_start;
    in_ch.valid = 1'b0;
    in_ch.action = 1'b0;
    in_ch.data_byte = '0;
    out_ch.ready = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: field mode, tab, no ranges
    rx_idle_on = 1'b1;
    queue_text("a\tb\n");
    queue_text("x\n");
    queue_beat(1'b1, 8'hFF);
    queue_beat(1'b0, 8'h00);
    queue_beat(1'b0, 8'hFF);
    queue_beat(1'b1, 8'h00);
    queue_text("\n");
    wait_idle();

    // character mode: plain, reversed, open, unused and out-of-reach ranges
    write_reg(REG_CUT_MODE, 32'd1);
    write_reg(REG_RANGE_0, span(1'b0, 2, 1));
    write_reg(REG_RANGE_1, span(1'b0, 3, 5));
    write_reg(REG_RANGE_2, span(1'b1, 0, 7));
    write_reg(REG_RANGE_3, span(1'b1, 1023, 0));
    write_reg(REG_RANGE_4, 32'hFFFF_FFFF);
    queue_text("abcdefgh\n");
    wait_idle();

    // field mode with suppress, empty leading field
    write_reg(REG_CUT_MODE, 32'd0);
    write_reg(REG_DELIMITER, ",");
    write_reg(REG_SUPPRESS, 32'd1);
    write_reg(REG_RANGE_1, span(1'b0, 1, 1));
    queue_text("q\n");
    queue_text(",b,c\n");
    wait_idle();

    // random phases
    phase = 0;
    while (random_beats < RANDOM_BEATS) begin
      random_settings(phase);
      tx_idle_on = (phase % 4 != 1) && ($urandom_range(0, 3) != 0);
      rx_idle_on = (phase % 4 != 1) && ($urandom_range(0, 3) != 0);
      if (phase == 0) hold_asked <= hold_asked + 1;
      phase_goal = $urandom_range(30, 60);
      phase_start = random_beats;
      while (random_beats - phase_start < phase_goal && random_beats < RANDOM_BEATS) begin
        queue_line();
        // sender waits for the output to drain mid-phase
        if (phase == 2 && random_beats - phase_start >= phase_goal / 2 &&
            random_beats - phase_start < phase_goal / 2 + 16)
          wait_results();
      end
      queue_beat(1'b1, 8'($urandom_range(0, 255)));
      wait_idle();
      phase++;
    end

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/lfcs_pkg.sv
hdl/lfcs_in_if.sv
hdl/lfcs_out_if.sv
hdl/lfcs_regs.sv
hdl/lfcs_dpath.sv
hdl/lfcs_ctrl.sv
hdl/line_field_column_selector.sv
hdl/lfcs_checker.sv
test/line_field_column_selector_test.sv
